/* rtl/core/hvn_pkg.sv */
package hvn_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_LENGTH  = 4096;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int SLOT_W      = 2;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = 3 * MAX_WIDTH;
  localparam int VEC_W       = 18;
  localparam int Q_ONE       = 16384;
  localparam int FACE_Y      = 256;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_LENGTH = 1'b1;

  typedef struct packed {
    logic signed [15:0] height;
    logic               flush;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [11:0]        point_row;
    logic [9:0]         point_col;
    logic               grid_done;
  } out_word_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec18_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FACE,
    S_FACE_WAIT,
    S_FINAL_WAIT,
    S_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_SQRT,
    N_DIV_INIT,
    N_DIV
  } norm_state_t;

endpackage

/* rtl/core/hvn_line_store.sv */
module hvn_line_store import hvn_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [0:STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/hvn_norm_unit.sv */
module hvn_norm_unit import hvn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  vec18_t vec,
  output logic   done,
  output vec16_t res
);

  norm_state_t state, state_next;

  vec18_t      vin;
  logic [16:0] mag0, mag1, mag2;
  logic [1:0]  sq_idx;
  logic [33:0] prod;
  logic [34:0] nsum;
  logic [62:0] x, root, bitv;
  logic [31:0] s;
  logic [1:0]  comp;
  logic [3:0]  dstep;
  logic [46:0] rem, dvs;
  logic [15:0] q;

  logic [16:0] mag_sel, mag_c;
  logic [34:0] nsum_new;
  logic [62:0] trial;
  logic        take;
  logic [62:0] root_new;
  logic        dtake;
  logic [15:0] q_new;
  logic [15:0] q_clamp;
  logic signed [15:0] comp_res;
  logic        comp_neg;

  function automatic logic [16:0] abs18(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[16:0];
  endfunction

  always_comb begin
    mag_sel  = (sq_idx == 2'd0) ? mag0 : (sq_idx == 2'd1) ? mag1 : mag2;
    mag_c    = (comp == 2'd0) ? mag0 : (comp == 2'd1) ? mag1 : mag2;
    comp_neg = (comp == 2'd0) ? (vin.x < 0) : (comp == 2'd1) ? (vin.y < 0) : (vin.z < 0);
    nsum_new = nsum + 35'(prod);
    // digit-by-digit square root step
    trial    = root + bitv;
    take     = (x >= trial);
    root_new = take ? ((root >> 1) + bitv) : (root >> 1);
    // restoring division step
    dtake    = (rem >= dvs);
    q_new    = {q[14:0], dtake};
    q_clamp  = (s == 32'd0) ? 16'd0 : (q_new > 16'(Q_ONE)) ? 16'(Q_ONE) : q_new;
    comp_res = comp_neg ? -$signed(q_clamp) : $signed(q_clamp);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:     if (start) state_next = N_SQ;
      N_SQ:       if (sq_idx == 2'd3) state_next = N_SQRT;
      N_SQRT:     if (bitv == 63'd1) state_next = N_DIV_INIT;
      N_DIV_INIT: state_next = N_DIV;
      N_DIV: begin
        if (dstep == 4'd15) begin
          state_next = (comp == 2'd2) ? N_IDLE : N_DIV_INIT;
        end
      end
      default:    state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == N_DIV) && (dstep == 4'd15) && (comp == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        vin    <= vec;
        mag0   <= abs18(vec.x);
        mag1   <= abs18(vec.y);
        mag2   <= abs18(vec.z);
        sq_idx <= 2'd0;
        nsum   <= '0;
      end
      N_SQ: begin
        if (sq_idx != 2'd3) begin
          prod <= mag_sel * mag_sel;
        end
        if (sq_idx != 2'd0) begin
          nsum <= nsum_new;
        end
        sq_idx <= sq_idx + 2'd1;
        x      <= {nsum_new[33:0], 28'd0, 1'b0} >> 1;
        root   <= '0;
        bitv   <= 63'd1 << 62;
        comp   <= 2'd0;
      end
      N_SQRT: begin
        if (take) begin
          x <= x - trial;
        end
        root <= root_new;
        bitv <= bitv >> 2;
        s    <= root_new[31:0];
      end
      N_DIV_INIT: begin
        rem   <= {2'd0, mag_c, 28'd0} + 47'(s >> 1);
        dvs   <= {s, 15'd0};
        q     <= '0;
        dstep <= '0;
      end
      N_DIV: begin
        if (dtake) begin
          rem <= rem - dvs;
        end
        dvs   <= dvs >> 1;
        q     <= q_new;
        dstep <= dstep + 4'd1;
        if (dstep == 4'd15) begin
          case (comp)
            2'd0:    res.x <= comp_res;
            2'd1:    res.y <= comp_res;
            default: res.z <= comp_res;
          endcase
          comp <= comp + 2'd1;
        end
      end
      default: begin
        sq_idx <= 2'd0;
      end
    endcase
  end

endmodule

/* rtl/core/heightmap_vertex_normals.sv */
// each vector normalization runs in the shared iterative unit (squaring, square root, then
// a divide per component); a point needs two to five of them plus line store reads of the
// centre, left, right and upper heights
// throughput: one word at a time; a word that gives no normal is taken while the block stays idle
// reset: synchronous, clears position, flush flag and handshakes; line store is not cleared
module heightmap_vertex_normals import hvn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [12:0] cfg_data
);

  ctl_state_t state, state_next;

  logic [10:0] grid_width;
  logic [12:0] grid_length;
  logic [10:0] eff_w;
  logic [12:0] eff_l;

  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [SLOT_W-1:0] row_slot;
  logic              flushing;

  logic [ROW_W-1:0]  e_row;
  logic [COL_W-1:0]  e_col;
  logic [SLOT_W-1:0] c_slot, u_slot;
  logic has_up, has_down, has_left, has_right, e_done;
  logic signed [15:0] h_down, hc, hl, hr, hu;
  logic [2:0] rd_step;
  logic [2:0] face_idx;
  logic signed [VEC_W-1:0] ax, ay, az;

  logic accept, take_stream, take_flush, emit_now;
  logic col_last, row_last;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] rdata;
  logic signed [VEC_W-1:0] dl, dr, du, dd;
  logic face_ok;
  logic norm_start, norm_done;
  vec18_t norm_vec;
  vec16_t norm_res;
  logic out_free;

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] sl);
    return (sl == 2'd0) ? 2'd2 : sl - 2'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 11'd256;
      grid_length <= 13'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[10:0];
        CFG_GRID_LENGTH: grid_length <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  assign eff_w = (grid_width < 11'd2) ? 11'd2 :
                 (grid_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : grid_width;
  assign eff_l = (grid_length < 13'd2) ? 13'd2 :
                 (grid_length > 13'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : grid_length;

  assign col_last    = ({1'b0, col_count} + 11'd1) >= eff_w;
  assign row_last    = ({1'b0, row_count} + 13'd1) >= eff_l;
  assign accept      = in_valid && in_ready;
  assign take_stream = accept && !flushing && !in_data.flush;
  assign take_flush  = accept && flushing && in_data.flush;
  assign emit_now    = (take_stream && (row_count != '0)) || take_flush;
  assign out_free    = !out_valid || out_ready;

  hvn_line_store u_store (
    .clk   (clk),
    .we    (take_stream),
    .waddr ({row_slot, col_count}),
    .wdata (in_data.height),
    .raddr (raddr),
    .rdata (rdata)
  );

  // height differences to the neighbours, zero where a neighbour is missing
  assign dl = has_left  ? (VEC_W'(hl) - VEC_W'(hc)) : '0;
  assign dr = has_right ? (VEC_W'(hr) - VEC_W'(hc)) : '0;
  assign du = has_up    ? (VEC_W'(hu) - VEC_W'(hc)) : '0;
  assign dd = has_down  ? (VEC_W'(h_down) - VEC_W'(hc)) : '0;

  always_comb begin
    case (face_idx)
      3'd0:    face_ok = has_left && has_down;
      3'd1:    face_ok = has_down && has_right;
      3'd2:    face_ok = has_right && has_up;
      3'd3:    face_ok = has_up && has_left;
      default: face_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (rd_step)
      3'd1:    raddr = {c_slot, e_col - 10'd1};
      3'd2:    raddr = {c_slot, e_col + 10'd1};
      3'd3:    raddr = {u_slot, e_col};
      default: raddr = {c_slot, e_col};
    endcase
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    norm_start = 1'b0;
    norm_vec.y = VEC_W'(FACE_Y);
    norm_vec.x = (face_idx == 3'd0 || face_idx == 3'd3) ? dl : -dr;
    norm_vec.z = (face_idx == 3'd0 || face_idx == 3'd1) ? -dd : du;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept && emit_now) state_next = S_READ;
      end
      S_READ: begin
        if (rd_step == 3'd4) state_next = S_FACE;
      end
      S_FACE: begin
        if (face_idx == 3'd4) begin
          norm_start = 1'b1;
          norm_vec   = '{x: ax, y: ay, z: az};
          state_next = S_FINAL_WAIT;
        end else if (face_ok) begin
          norm_start = 1'b1;
          state_next = S_FACE_WAIT;
        end
      end
      S_FACE_WAIT: begin
        if (norm_done) state_next = S_FACE;
      end
      S_FINAL_WAIT: begin
        if (norm_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
      row_slot  <= '0;
      flushing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take_stream) begin
        if (col_last) begin
          col_count <= '0;
          if (row_last) begin
            flushing <= 1'b1;
          end else begin
            row_count <= row_count + 12'd1;
            row_slot  <= (row_slot == 2'd2) ? 2'd0 : row_slot + 2'd1;
          end
        end else begin
          col_count <= col_count + 10'd1;
        end
      end else if (take_flush) begin
        if (col_last) begin
          row_count <= '0;
          col_count <= '0;
          row_slot  <= '0;
          flushing  <= 1'b0;
        end else begin
          col_count <= col_count + 10'd1;
        end
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_stream) begin
      e_row     <= row_count - 12'd1;
      e_col     <= col_count;
      c_slot    <= slot_dec(row_slot);
      u_slot    <= slot_dec(slot_dec(row_slot));
      has_up    <= row_count >= 12'd2;
      has_down  <= 1'b1;
      has_left  <= col_count != '0;
      has_right <= !col_last;
      e_done    <= 1'b0;
      h_down    <= in_data.height;
    end else if (take_flush) begin
      e_row     <= row_count;
      e_col     <= col_count;
      c_slot    <= row_slot;
      u_slot    <= slot_dec(row_slot);
      has_up    <= row_count != '0;
      has_down  <= 1'b0;
      has_left  <= col_count != '0;
      has_right <= !col_last;
      e_done    <= col_last;
    end
    if (state == S_IDLE) begin
      rd_step  <= '0;
      face_idx <= '0;
      ax <= '0;
      ay <= '0;
      az <= '0;
    end
    if (state == S_READ) begin
      rd_step <= rd_step + 3'd1;
      case (rd_step)
        3'd1:    hc <= $signed(rdata);
        3'd2:    hl <= $signed(rdata);
        3'd3:    hr <= $signed(rdata);
        3'd4:    hu <= $signed(rdata);
        default: hc <= hc;
      endcase
    end
    if (state == S_FACE && face_idx != 3'd4 && !face_ok) begin
      face_idx <= face_idx + 3'd1;
    end
    if (state == S_FACE_WAIT && norm_done) begin
      ax <= ax + VEC_W'(norm_res.x);
      ay <= ay + VEC_W'(norm_res.y);
      az <= az + VEC_W'(norm_res.z);
      face_idx <= face_idx + 3'd1;
    end
    if (state == S_OUT && out_free) begin
      out_data.normal_x  <= norm_res.x;
      out_data.normal_y  <= norm_res.y;
      out_data.normal_z  <= -norm_res.z;
      out_data.point_row <= e_row;
      out_data.point_col <= e_col;
      out_data.grid_done <= e_done;
    end
  end

  hvn_norm_unit u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vec   (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

endmodule

/* rtl/core/hvn_checker.sv */
module hvn_checker import hvn_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      cfg_we,
  input logic      cfg_index,
  input logic [12:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output word changed while stalled");

  a_xz_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.normal_x >= -16'sd16384) && (out_data.normal_x <= 16'sd16384) &&
                  (out_data.normal_z >= -16'sd16384) && (out_data.normal_z <= 16'sd16384))
    else $error("normal component out of unit range");

  a_y_up: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.normal_y > 16'sd0) && (out_data.normal_y <= 16'sd16384))
    else $error("normal y not positive");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (.*);
